// ----- design/tlpq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlpq_pkg: shared types and constants
// Codes and widths for the three-level priority queue.
// ----------------------------------------------------------------------------
package tlpq_pkg;
  localparam int ID_COUNT_DEF = 64;
  localparam int ID_W         = 6;
  localparam int LINK_W       = 7;
  localparam logic [LINK_W-1:0] NIL = 7'd127;

  typedef enum logic [2:0] {
    MODE_ADMIT  = 3'd0,
    MODE_QUERY  = 3'd1,
    MODE_SERVE  = 3'd2,
    MODE_DEMOTE = 3'd3,
    MODE_LIST   = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUP       = 3'd1,
    ST_BAD_LEVEL = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_NONE_REC  = 3'd5
  } status_t;

  typedef struct packed {
    logic [2:0]      mode;
    logic [ID_W-1:0] entry_id;
    logic [1:0]      level_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [ID_W-1:0] entry_out;
    logic [1:0]      level_out;
    logic            last;
  } out_item_t;
endpackage
`default_nettype wire

// ----- design/tlpq_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlpq_if: valid/ready channel
// Carries one payload of a given type with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tlpq_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/tlpq_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlpq_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tlpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- design/three_level_priority_queue_demote_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// three_level_priority_queue_demote_core: strict-priority queue, three levels
// Admit, query, serve, demote and list over doubly linked FIFO levels.
// ----------------------------------------------------------------------------
// One transaction is processed at a time. The links {level, prev, next} of
// every entry sit in one RAM of ID_COUNT words with a registered read. Each
// neighbor fix is a read followed by a write-back. Head and tail of the three
// levels, and the present and recovered bits, are flip-flops cleared at reset,
// so no clearing pass is needed. Path of a transaction through the states:
// - decode, then output, for every error status, an admit into an empty
//   level and a serve on an empty queue;
// - self read then output for a query; a read and write-back of the old tail
//   for an admit behind an existing tail;
// - the self read for a serve, plus a successor fix when there is one;
// - for a demote: the self read, up to two unlink fixes (predecessor,
//   successor), and one head fix when the entry moves to a non-empty level.
// The input is ready again in the cycle after the result register loads.
// The result waits in its own register: the next transaction is taken while
// it waits, and its result stalls only when it is ready before the previous
// one is taken.
// List walks the recovered bits one ID per cycle and emits each recovered ID
// when the next one is found (or the walk ends), holding the walk while a
// result waits.
module three_level_priority_queue_demote_core
  import tlpq_pkg::*;
#(
  parameter int ID_COUNT = ID_COUNT_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  tlpq_if.sink     in_ch,
  tlpq_if.source   out_ch
);
  localparam int AW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int RW = 2 + 2 * LINK_W;
  localparam int CW = $clog2(ID_COUNT + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SELF, S_PREV_RD, S_PREV_WR, S_NEXT_RD, S_NEXT_WR,
    S_PUSH, S_HEAD_WR, S_LIST, S_OUT
  } state_t;

  state_t               state_r;
  logic [ID_COUNT-1:0]  present_r, recovered_r;
  logic [LINK_W-1:0]    head_r [3];
  logic [LINK_W-1:0]    tail_r [3];
  logic [2:0]           mode_r;
  logic [ID_W-1:0]      id_r;
  logic [1:0]           lvl_r;         // admit level, or level index on serve
  logic [LINK_W-1:0]    sp_r, sn_r;    // self prev/next, or neighbor to fix
  logic [1:0]           sl_r;          // current level of the entry
  logic [CW-1:0]        scan_r;
  logic                 pend_v_r;      // a recovered ID waits to be emitted
  logic [ID_W-1:0]      pend_id_r;
  out_item_t            rs_r;          // result being built
  out_item_t            res_r;         // result shown on the output
  logic                 res_v_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [RW-1:0] wdata, rdata;

  tlpq_ram #(.WIDTH(RW), .DEPTH(ID_COUNT)) u_links (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  function automatic out_item_t mk_res(logic [2:0] st, logic [ID_W-1:0] ent);
    out_item_t r;
    r = '{status: st, entry_out: ent, level_out: 2'd0, last: 1'b1};
    return r;
  endfunction

  wire [1:0]        rd_lvl  = rdata[RW-1 -: 2];
  wire [LINK_W-1:0] rd_prev = rdata[2*LINK_W-1 -: LINK_W];
  wire [LINK_W-1:0] rd_next = rdata[LINK_W-1:0];
  wire              id_ok   = ({1'b0, id_r} < (ID_W+1)'(ID_COUNT));
  wire [AW-1:0]     id_a    = AW'(id_r);
  wire              id_pres = id_ok && present_r[id_a];
  wire [1:0]        adm_li  = lvl_r - 2'd1;
  wire              adm_go  = (state_r == S_DECODE) && (mode_r == MODE_ADMIT) && id_ok &&
                              !id_pres && (lvl_r != 2'd0);
  // level of the entry being unlinked: demote clamps a zero level to 1
  wire [1:0]        self_cur = (mode_r == MODE_DEMOTE) ?
                               ((rd_lvl == 2'd0) ? 2'd1 : rd_lvl) : (lvl_r + 2'd1);
  wire [1:0]        self_li  = self_cur - 2'd1;
  wire [1:0]        push_li  = sl_r - 2'd2;
  wire              push_go  = (state_r == S_PUSH) && (mode_r == MODE_DEMOTE) &&
                               (sl_r != 2'd1);
  wire              out_acc  = out_ch.valid && out_ch.ready;
  wire              out_free = !res_v_r || out_acc;
  wire              scan_end = (scan_r == CW'(ID_COUNT));
  wire              rec_hit  = !scan_end && recovered_r[scan_r[AW-1:0]];

  // serve level choice: highest non-empty
  logic [1:0] srv_li;
  always_comb begin
    priority if (head_r[2] != NIL) srv_li = 2'd2;
    else if (head_r[1] != NIL)     srv_li = 2'd1;
    else                           srv_li = 2'd0;
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = res_v_r;
  assign out_ch.data  = res_r;

  // one read and one write per cycle, driven from state
  always_comb begin
    we    = 1'b0;
    waddr = id_a;
    wdata = '0;
    raddr = id_a;
    unique case (state_r)
      S_DECODE: begin
        // read self (or the head to serve); append writes the new entry
        if (mode_r == MODE_SERVE) raddr = head_r[srv_li][AW-1:0];
        if (adm_go) begin
          we    = 1'b1;
          wdata = {lvl_r, tail_r[adm_li], NIL};
        end
      end
      S_PREV_RD: raddr = sp_r[AW-1:0];
      S_PREV_WR: begin
        we    = 1'b1;
        waddr = sp_r[AW-1:0];
        wdata = {rd_lvl, rd_prev, sn_r};
      end
      S_NEXT_RD: raddr = sn_r[AW-1:0];
      S_NEXT_WR: begin
        we    = 1'b1;
        waddr = sn_r[AW-1:0];
        wdata = {rd_lvl, sp_r, rd_next};
      end
      S_PUSH: begin
        if (push_go) begin
          we    = 1'b1;
          wdata = {sl_r - 2'd1, NIL, head_r[push_li]};
          raddr = head_r[push_li][AW-1:0];
        end
      end
      S_HEAD_WR: begin
        we    = 1'b1;
        waddr = sn_r[AW-1:0];
        wdata = {rd_lvl, {1'b0, id_r}, rd_next};
      end
      default: ;
    endcase
  end

  // output register load
  logic      res_ld;
  out_item_t res_nxt;
  always_comb begin
    res_ld  = 1'b0;
    res_nxt = rs_r;
    if (state_r == S_OUT) begin
      res_ld = out_free;
    end else if (state_r == S_LIST) begin
      res_ld  = out_free && (scan_end || (rec_hit && pend_v_r));
      res_nxt = '{status: pend_v_r ? ST_OK : ST_NONE_REC,
                  entry_out: pend_v_r ? pend_id_r : '0,
                  level_out: 2'd0, last: scan_end};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      present_r   <= '0;
      recovered_r <= '0;
      for (int i = 0; i < 3; i++) begin
        head_r[i] <= NIL;
        tail_r[i] <= NIL;
      end
      res_v_r <= 1'b0;
    end else begin
      if (res_ld) begin
        res_r   <= res_nxt;
        res_v_r <= 1'b1;
      end else if (out_acc) begin
        res_v_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            mode_r  <= in_ch.data.mode;
            id_r    <= in_ch.data.entry_id;
            lvl_r   <= in_ch.data.level_in;
            state_r <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (mode_r)
            MODE_ADMIT: begin
              priority if (!id_ok) begin
                rs_r <= mk_res(ST_UNKNOWN, id_r); state_r <= S_OUT;
              end else if (id_pres) begin
                rs_r <= mk_res(ST_DUP, id_r); state_r <= S_OUT;
              end else if (lvl_r == 2'd0) begin
                rs_r <= mk_res(ST_BAD_LEVEL, id_r); state_r <= S_OUT;
              end else begin
                // append at the tail; the self word is written this cycle
                rs_r            <= mk_res(ST_OK, id_r);
                present_r[id_a] <= 1'b1;
                tail_r[adm_li]  <= {1'b0, id_r};
                if (tail_r[adm_li] == NIL) begin
                  head_r[adm_li] <= {1'b0, id_r};
                  state_r        <= S_OUT;
                end else begin
                  sp_r    <= tail_r[adm_li];   // old tail.next = id
                  sn_r    <= {1'b0, id_r};
                  state_r <= S_PREV_RD;
                end
              end
            end
            MODE_QUERY, MODE_DEMOTE: begin
              if (!id_pres) begin
                rs_r <= mk_res(ST_UNKNOWN, id_r); state_r <= S_OUT;
              end else begin
                rs_r <= mk_res(ST_OK, id_r); state_r <= S_SELF;
              end
            end
            MODE_SERVE: begin
              if (head_r[srv_li] == NIL) begin
                rs_r    <= mk_res(ST_EMPTY, '0);
                state_r <= S_OUT;
              end else begin
                id_r    <= head_r[srv_li][ID_W-1:0];
                lvl_r   <= srv_li;
                rs_r    <= mk_res(ST_OK, head_r[srv_li][ID_W-1:0]);
                state_r <= S_SELF;
              end
            end
            MODE_LIST: begin
              scan_r   <= '0;
              pend_v_r <= 1'b0;
              state_r  <= S_LIST;
            end
            default: state_r <= S_IDLE;   // unused modes: drop, no result
          endcase
        end
        S_SELF: begin
          if (mode_r == MODE_QUERY) begin
            rs_r.level_out <= rd_lvl;
            state_r        <= S_OUT;
          end else begin
            // unlink: head/tail updates here, neighbor fixes follow
            sp_r <= rd_prev;
            sn_r <= rd_next;
            sl_r <= self_cur;
            if (rd_prev == NIL) head_r[self_li] <= rd_next;
            if (rd_next == NIL) tail_r[self_li] <= rd_prev;
            priority if (rd_prev != NIL) state_r <= S_PREV_RD;
            else if (rd_next != NIL)     state_r <= S_NEXT_RD;
            else                         state_r <= S_PUSH;
          end
        end
        S_PREV_RD: state_r <= S_PREV_WR;
        S_PREV_WR: begin
          priority if (mode_r == MODE_ADMIT) state_r <= S_OUT;
          else if (sn_r != NIL)              state_r <= S_NEXT_RD;
          else                               state_r <= S_PUSH;
        end
        S_NEXT_RD: state_r <= S_NEXT_WR;
        S_NEXT_WR: state_r <= S_PUSH;
        S_PUSH: begin
          if (!push_go) begin
            // serve and level-1 demote end after the unlink
            present_r[id_a] <= 1'b0;
            if (mode_r == MODE_DEMOTE) recovered_r[id_a] <= 1'b1;
            state_r <= S_OUT;
          end else begin
            // move to the front of the next lower level
            head_r[push_li] <= {1'b0, id_r};
            if (head_r[push_li] == NIL) begin
              tail_r[push_li] <= {1'b0, id_r};
              state_r         <= S_OUT;
            end else begin
              sn_r    <= head_r[push_li];   // old head.prev = id
              state_r <= S_HEAD_WR;
            end
          end
        end
        S_HEAD_WR: state_r <= S_OUT;
        S_LIST: begin
          if (scan_end) begin
            if (out_free) state_r <= S_IDLE;
          end else if (rec_hit) begin
            // hold the walk while the pending ID cannot be emitted
            if (!pend_v_r || out_free) begin
              pend_v_r  <= 1'b1;
              pend_id_r <= ID_W'(scan_r);
              scan_r    <= scan_r + CW'(1);
            end
          end else begin
            scan_r <= scan_r + CW'(1);
          end
        end
        S_OUT: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
    else $error("result changed while stalled");
  // Served entry leaves the present set.
  a_serve_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH && mode_r == MODE_SERVE) |=> !present_r[$past(id_a)])
    else $error("served entry still present");
  // Head and tail of a level are empty together.
  a_ht: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> (((head_r[0] == NIL) == (tail_r[0] == NIL)) &&
                           ((head_r[1] == NIL) == (tail_r[1] == NIL)) &&
                           ((head_r[2] == NIL) == (tail_r[2] == NIL))))
    else $error("level head/tail mismatch");
endmodule
`default_nettype wire

// ----- bench/three_level_priority_queue_demote_core_test.sv -----
// ----------------------------------------------------------------------------
// three_level_priority_queue_demote_core_test: self-checking bench
// Drives admit, query, serve, demote and list transactions, including unused
// modes, into the core and checks every result against a local model of the
// three leveled FIFOs, under several idle and stall patterns.
// ----------------------------------------------------------------------------
module three_level_priority_queue_demote_core_test;
  import tlpq_pkg::*;

  localparam int NIDS = 64;
  localparam int LIMIT = 400000;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tlpq_if #(.T(in_item_t))  in_ch ();
  tlpq_if #(.T(out_item_t)) out_ch ();

  three_level_priority_queue_demote_core #(.ID_COUNT(NIDS)) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Model state: per-level FIFOs kept as queues of IDs.
  bit       queued [NIDS];
  bit       rescued [NIDS];
  bit [1:0] lvl_of [NIDS];
  logic [ID_W-1:0] fifo [3][$];

  in_item_t  pending_items [$];
  out_item_t expected_results [$];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_off = 0;
  int  errors = 0;
  int  cycles = 0;
  bit  in_taken = 1'b0;

  // Remove one ID from a level FIFO.
  function automatic void fifo_drop(int li, logic [ID_W-1:0] id);
    for (int i = 0; i < fifo[li].size(); i++) begin
      if (fifo[li][i] == id) begin
        fifo[li].delete(i);
        break;
      end
    end
  endfunction

  function automatic void expect_result(out_item_t r);
    expected_results = {expected_results, r};
  endfunction

  function automatic void queue_item(in_item_t it);
    pending_items = {pending_items, it};
  endfunction

  // Advance the model by one accepted transaction and queue its results.
  function automatic void predict_queue_results(in_item_t it);
    out_item_t r;
    logic [ID_W-1:0] id;
    int cur;
    bit found;
    id = it.entry_id;
    r = '0;
    r.entry_out = id;
    r.last = 1'b1;
    case (it.mode)
      MODE_ADMIT: begin
        if (queued[id]) begin
          r.status = ST_DUP;
        end else if (it.level_in == 2'd0) begin
          r.status = ST_BAD_LEVEL;
        end else begin
          queued[id] = 1'b1;
          lvl_of[id] = it.level_in;
          fifo[it.level_in - 1] = {fifo[it.level_in - 1], id};
          r.status = ST_OK;
        end
        expect_result(r);
      end
      MODE_QUERY: begin
        if (!queued[id]) begin
          r.status = ST_UNKNOWN;
        end else begin
          r.status = ST_OK;
          r.level_out = lvl_of[id];
        end
        expect_result(r);
      end
      MODE_SERVE: begin
        found = 1'b0;
        for (int li = 2; li >= 0 && !found; li--) begin
          if (fifo[li].size() != 0) begin
            r.entry_out = fifo[li][0];
            fifo[li].delete(0);
            queued[r.entry_out] = 1'b0;
            r.status = ST_OK;
            found = 1'b1;
          end
        end
        if (!found) begin
          r.status = ST_EMPTY;
          r.entry_out = '0;
        end
        expect_result(r);
      end
      MODE_DEMOTE: begin
        if (!queued[id]) begin
          r.status = ST_UNKNOWN;
        end else begin
          cur = int'(lvl_of[id]);
          fifo_drop(cur - 1, id);
          if (cur == 1) begin
            queued[id] = 1'b0;
            rescued[id] = 1'b1;
          end else begin
            fifo[cur - 2].insert(0, id);
            lvl_of[id] = 2'(cur - 1);
          end
          r.status = ST_OK;
        end
        expect_result(r);
      end
      MODE_LIST: begin
        found = 1'b0;
        for (int i = 0; i < NIDS; i++) begin
          if (rescued[i]) begin
            if (found) expect_result(r);
            r.status = ST_OK;
            r.entry_out = ID_W'(i);
            r.last = 1'b0;
            found = 1'b1;
          end
        end
        if (!found) begin
          r.status = ST_NONE_REC;
          r.entry_out = '0;
        end
        r.last = 1'b1;
        expect_result(r);
      end
      default: ;  // unused modes: no result
    endcase
  endfunction

  // Driver: offer queued items, idle at random on the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else if (!in_ch.valid || in_taken) begin
      // The previous item either was never offered or was taken at the last
      // rising edge; pick the next one or go idle.
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= pending_items[0];
        pending_items.delete(0);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver stall, with an optional long hold-off counted here.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on input transactions, check output transactions.
  always @(posedge clk) begin
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) predict_queue_results(in_ch.data);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d entry %0d", out_ch.data.status,
                 out_ch.data.entry_out);
          errors++;
        end else begin
          out_item_t e;
          e = expected_results[0];
          expected_results.delete(0);
          if (out_ch.data.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_ch.data.status);
            errors++;
          end
          if (out_ch.data.entry_out !== e.entry_out) begin
            $error("entry_out: expected %0d, got %0d", e.entry_out, out_ch.data.entry_out);
            errors++;
          end
          if (out_ch.data.level_out !== e.level_out) begin
            $error("level_out: expected %0d, got %0d", e.level_out, out_ch.data.level_out);
            errors++;
          end
          if (out_ch.data.last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, out_ch.data.last);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[three_level_priority_queue_demote_core] ERROR");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic [2:0] m, int id, int lv);
    in_item_t it;
    it.mode = m;
    it.entry_id = ID_W'(id);
    it.level_in = 2'(lv);
    return it;
  endfunction

  // Random item: mostly useful operations on a small ID pool so that
  // duplicates, demotes and queries hit present entries.
  function automatic in_item_t random_item();
    int pick;
    int id;
    pick = $urandom_range(99);
    id = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(15);
    if (pick < 35) return make_item(MODE_ADMIT, id,
                                    ($urandom_range(9) == 0) ? 0 : $urandom_range(3, 1));
    if (pick < 50) return make_item(MODE_QUERY, id, $urandom_range(3));
    if (pick < 68) return make_item(MODE_SERVE, $urandom_range(63), $urandom_range(3));
    if (pick < 90) return make_item(MODE_DEMOTE, id, $urandom_range(3));
    if (pick < 96) return make_item(MODE_LIST, $urandom_range(63), $urandom_range(3));
    return make_item(3'($urandom_range(7, 5)), $urandom_range(63), $urandom_range(3));
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    fifo[0] = {};
    fifo[1] = {};
    fifo[2] = {};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty serve, empty list, unknown IDs, bad level, duplicate,
    // admit at every level, priority order, demote chain down to recovery,
    // readmission of a recovered entry and unused modes.
    queue_item(make_item(MODE_SERVE, 0, 0));
    queue_item(make_item(MODE_LIST, 0, 0));
    queue_item(make_item(MODE_QUERY, 63, 0));
    queue_item(make_item(MODE_DEMOTE, 5, 0));
    queue_item(make_item(MODE_ADMIT, 0, 0));
    queue_item(make_item(MODE_ADMIT, 0, 1));
    queue_item(make_item(MODE_ADMIT, 0, 2));
    queue_item(make_item(MODE_ADMIT, 63, 3));
    queue_item(make_item(MODE_ADMIT, 42, 2));
    queue_item(make_item(MODE_ADMIT, 21, 1));
    queue_item(make_item(MODE_QUERY, 63, 0));
    queue_item(make_item(MODE_DEMOTE, 63, 0));
    queue_item(make_item(MODE_DEMOTE, 63, 0));
    queue_item(make_item(MODE_QUERY, 63, 0));
    queue_item(make_item(MODE_DEMOTE, 63, 0));
    queue_item(make_item(MODE_DEMOTE, 21, 0));
    queue_item(make_item(MODE_LIST, 0, 0));
    queue_item(make_item(MODE_ADMIT, 63, 3));
    queue_item(make_item(3'd5, 1, 1));
    queue_item(make_item(3'd7, 2, 3));
    queue_item(make_item(MODE_SERVE, 0, 0));
    queue_item(make_item(MODE_SERVE, 0, 0));
    queue_item(make_item(MODE_SERVE, 0, 0));
    queue_item(make_item(MODE_SERVE, 0, 0));
    wait_drained();

    // Random phases: none, sender idle, receiver stall, both lightly.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 71 : (ph == 3) ? 8 : 0;
      recv_stall_pct = (ph == 2) ? 71 : (ph == 3) ? 8 : 0;
      for (int i = 0; i < 85; i++) queue_item(random_item());
      if (ph == 0) begin
        // Long receiver hold-off while the sender keeps offering.
        @(negedge clk);
        hold_off = 300;
      end
      wait_drained();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[three_level_priority_queue_demote_core] OK");
    end else begin
      $display("[three_level_priority_queue_demote_core] ERROR");
    end
    $finish;
  end
endmodule
